// File: rtl/core/spq_pkg.sv
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Shared types, codes and defaults for the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int unsigned DefaultDepth = 16;
  localparam int unsigned PayloadW     = 64;
  localparam int unsigned PrioW        = 16;
  localparam int unsigned OccW         = 5;

  typedef enum logic {
    CMD_ENQ = 1'b0,
    CMD_DEQ = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    STATUS_ENQ   = 2'd0,
    STATUS_POP   = 2'd1,
    STATUS_EMPTY = 2'd2,
    STATUS_FULL  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PLACE,
    ST_POP,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [PayloadW-1:0]     payload;
    logic signed [PrioW-1:0] prio;
  } entry_t;

endpackage

// File: rtl/core/spq_req_if.sv
// ----------------------------------------------------------------------------
// Sorted priority queue request channel
// Carries one command item with its payload and priority.
// ----------------------------------------------------------------------------
interface spq_req_if;

  logic               valid;
  logic               ready;
  logic               cmd;
  logic [63:0]        payload;
  logic signed [15:0] prio;

  modport source (output valid, output cmd, output payload, output prio, input ready);
  modport sink   (input valid, input cmd, input payload, input prio, output ready);

endinterface

// File: rtl/core/spq_rsp_if.sv
// ----------------------------------------------------------------------------
// Sorted priority queue response channel
// Carries one result item with status, popped entry and occupancy.
// ----------------------------------------------------------------------------
interface spq_rsp_if;

  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [63:0]        out_payload;
  logic signed [15:0] out_prio;
  logic [4:0]         occupancy;

  modport source (output valid, output status, output out_payload, output out_prio,
                  output occupancy, input ready);
  modport sink   (input valid, input status, input out_payload, input out_prio,
                  input occupancy, output ready);

endinterface

// File: rtl/core/spq_store.sv
// ----------------------------------------------------------------------------
// Sorted priority queue entry store
// Circular entry memory addressed by logical position from the head, with
// one write port and one registered read port.
// ----------------------------------------------------------------------------
module spq_store
  import spq_pkg::*;
#(
  parameter int unsigned DEPTH = DefaultDepth
) (
  input  logic                     clk_i,
  input  logic [$clog2(DEPTH)-1:0] head_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_idx_i,
  input  entry_t                   wr_data_i,
  input  logic [$clog2(DEPTH)-1:0] rd_idx_i,
  output entry_t                   rd_data_o
);

  localparam int unsigned AW = $clog2(DEPTH);

  entry_t          mem_q [DEPTH];
  entry_t          rd_data_q;
  logic   [AW:0]   wr_sum;
  logic   [AW:0]   rd_sum;
  logic   [AW-1:0] wr_addr;
  logic   [AW-1:0] rd_addr;

  always_comb begin
    wr_sum = {1'b0, head_i} + {1'b0, wr_idx_i};
    rd_sum = {1'b0, head_i} + {1'b0, rd_idx_i};
    if (wr_sum >= (AW+1)'(DEPTH)) begin
      wr_sum = wr_sum - (AW+1)'(DEPTH);
    end
    if (rd_sum >= (AW+1)'(DEPTH)) begin
      rd_sum = rd_sum - (AW+1)'(DEPTH);
    end
    wr_addr = wr_sum[AW-1:0];
    rd_addr = rd_sum[AW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[rd_addr];
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: rtl/core/sorted_priority_queue_unit.sv
// ----------------------------------------------------------------------------
// Sorted priority queue unit
// Bounded priority queue of DEPTH entries kept in ascending priority order.
// ----------------------------------------------------------------------------
// Entries live in a circular single-port-write, single-port-read memory and
// are kept sorted from the head. A dequeue reads the head and advances the
// head pointer. An enqueue walks from the tail toward the head, moving each
// entry whose priority is equal or greater up by one place, one entry per
// cycle through the memory's read and write ports, then writes the new
// entry; at most DEPTH - 1 entries are moved. A rejected enqueue or a dequeue
// from an empty queue goes straight to its result. A finished result waits
// in an output register, so the next item is accepted while it is still
// pending; a later result is held until the waiting one has been taken.
// Only one item is in progress at a time.
module sorted_priority_queue_unit
  import spq_pkg::*;
#(
  parameter int unsigned DEPTH = DefaultDepth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  spq_req_if.sink   req_i,
  spq_rsp_if.source rsp_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  state_e          state_q, state_d;
  logic [CW-1:0]   count_q, count_d;
  logic [AW-1:0]   head_q, head_d;
  logic [AW-1:0]   k_q, k_d;
  entry_t          new_q, new_d;
  status_e         res_status_q, res_status_d;
  entry_t          res_entry_q, res_entry_d;

  logic            out_valid_q, out_valid_d;
  status_e         out_status_q, out_status_d;
  entry_t          out_entry_q, out_entry_d;
  logic [OccW-1:0] out_occ_q, out_occ_d;

  logic            accept;
  logic            wr_en;
  logic [AW-1:0]   wr_idx;
  entry_t          wr_data;
  logic [AW-1:0]   rd_idx;
  entry_t          rd_data;

  spq_store #(
    .DEPTH(DEPTH)
  ) u_store (
    .clk_i    (clk_i),
    .head_i   (head_q),
    .wr_en_i  (wr_en),
    .wr_idx_i (wr_idx),
    .wr_data_i(wr_data),
    .rd_idx_i (rd_idx),
    .rd_data_o(rd_data)
  );

  assign req_i.ready = (state_q == ST_IDLE);
  assign accept      = req_i.valid && req_i.ready;

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    head_d       = head_q;
    k_d          = k_q;
    new_d        = new_q;
    res_status_d = res_status_q;
    res_entry_d  = res_entry_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_entry_d  = out_entry_q;
    out_occ_d    = out_occ_q;
    wr_en        = 1'b0;
    wr_idx       = k_q;
    wr_data      = rd_data;
    rd_idx       = k_q - AW'(1) - AW'(1);

    if (out_valid_q && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          new_d = '{payload: req_i.payload, prio: req_i.prio};
          if (req_i.cmd == CMD_ENQ) begin
            if (count_q == CW'(DEPTH)) begin
              res_status_d = STATUS_FULL;
              res_entry_d  = '0;
              state_d      = ST_DONE;
            end else begin
              k_d    = AW'(count_q);
              rd_idx = AW'(count_q - CW'(1));
              if (count_q == '0) begin
                state_d = ST_PLACE;
              end else begin
                state_d = ST_SCAN;
              end
            end
          end else begin
            rd_idx = '0;
            if (count_q == '0) begin
              res_status_d = STATUS_EMPTY;
              res_entry_d  = '0;
              state_d      = ST_DONE;
            end else begin
              state_d = ST_POP;
            end
          end
        end
      end
      ST_SCAN: begin
        wr_en = 1'b1;
        if (rd_data.prio >= new_q.prio) begin
          k_d = k_q - AW'(1);
          if (k_q == AW'(1)) begin
            state_d = ST_PLACE;
          end
        end else begin
          wr_data      = new_q;
          count_d      = count_q + CW'(1);
          res_status_d = STATUS_ENQ;
          res_entry_d  = '0;
          state_d      = ST_DONE;
        end
      end
      ST_PLACE: begin
        wr_en        = 1'b1;
        wr_data      = new_q;
        count_d      = count_q + CW'(1);
        res_status_d = STATUS_ENQ;
        res_entry_d  = '0;
        state_d      = ST_DONE;
      end
      ST_POP: begin
        res_status_d = STATUS_POP;
        res_entry_d  = rd_data;
        count_d      = count_q - CW'(1);
        head_d       = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);
        state_d      = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_entry_d  = res_entry_q;
          out_occ_d    = OccW'(count_q);
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      head_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      head_q      <= head_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q          <= k_d;
    new_q        <= new_d;
    res_status_q <= res_status_d;
    res_entry_q  <= res_entry_d;
    out_status_q <= out_status_d;
    out_entry_q  <= out_entry_d;
    out_occ_q    <= out_occ_d;
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = out_status_q;
  assign rsp_o.out_payload = out_entry_q.payload;
  assign rsp_o.out_prio    = out_entry_q.prio;
  assign rsp_o.occupancy   = out_occ_q;

`ifndef ASSERT_OFF
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("Entry count exceeds the queue depth.");

  a_idle_count_stable : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && !accept) |=> $stable(count_q) && $stable(head_q))
    else $error("Queue state changed without an accepted item.");

  a_full_occupancy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q == STATUS_FULL) |-> out_occ_q == OccW'(DEPTH))
    else $error("Full status reported with the queue not full.");

  a_empty_occupancy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q == STATUS_EMPTY) |-> out_occ_q == '0)
    else $error("Empty status reported with entries stored.");

  a_scan_not_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN || state_q == ST_POP) |-> count_q != '0)
    else $error("Store walk started on an empty queue.");
`endif

endmodule

// File: tb/sv/spq_queue_checker.sv
// ----------------------------------------------------------------------------
// Sorted priority queue checker
// Watches the request and response channels and keeps its own sorted copy of
// the queue. Each accepted request item yields one expected response; each
// accepted response item is compared field by field with the oldest one.
// ----------------------------------------------------------------------------
module spq_queue_checker
  import spq_pkg::*;
#(
  parameter int unsigned DEPTH = DefaultDepth
) (
  input  logic clk_i,
  input  logic rst_ni,
  spq_req_if   req_i,
  spq_rsp_if   rsp_i,
  output int   err_cnt_o,
  output int   pending_o,
  output int   enq_cnt_o,
  output int   pop_cnt_o,
  output int   empty_cnt_o,
  output int   full_cnt_o,
  output int   peak_occ_o
);

  typedef struct packed {
    status_e                 status;
    logic [PayloadW-1:0]     payload;
    logic signed [PrioW-1:0] prio;
    logic [OccW-1:0]         occ;
  } queue_rsp_t;

  logic [PayloadW-1:0]     shadow_payload [DEPTH];
  logic signed [PrioW-1:0] shadow_prio    [DEPTH];
  int                      shadow_cnt;

  queue_rsp_t expected_rsp_q [$];
  queue_rsp_t oldest_rsp;
  int         mismatches;
  int         stat_enq, stat_pop, stat_empty, stat_full, stat_peak;

  function automatic queue_rsp_t apply_queue_cmd(input cmd_e cmd,
                                                 input logic [PayloadW-1:0] pay,
                                                 input logic signed [PrioW-1:0] pr);
    queue_rsp_t r;
    int         pos;
    r = '{status: STATUS_ENQ, payload: '0, prio: '0, occ: '0};
    if (cmd == CMD_ENQ) begin
      if (shadow_cnt >= DEPTH) begin
        r.status = STATUS_FULL;
        stat_full++;
      end else begin
        // A new entry goes ahead of every stored entry of equal priority.
        pos = 0;
        while (pos < shadow_cnt && shadow_prio[pos] < pr) pos++;
        for (int k = shadow_cnt; k > pos; k--) begin
          shadow_payload[k] = shadow_payload[k-1];
          shadow_prio[k]    = shadow_prio[k-1];
        end
        shadow_payload[pos] = pay;
        shadow_prio[pos]    = pr;
        shadow_cnt++;
        stat_enq++;
      end
    end else begin
      if (shadow_cnt == 0) begin
        r.status = STATUS_EMPTY;
        stat_empty++;
      end else begin
        r.status  = STATUS_POP;
        r.payload = shadow_payload[0];
        r.prio    = shadow_prio[0];
        for (int k = 1; k < shadow_cnt; k++) begin
          shadow_payload[k-1] = shadow_payload[k];
          shadow_prio[k-1]    = shadow_prio[k];
        end
        shadow_cnt--;
        stat_pop++;
      end
    end
    if (shadow_cnt > stat_peak) stat_peak = shadow_cnt;
    r.occ = OccW'(shadow_cnt);
    return r;
  endfunction

  task automatic compare_rsp(input queue_rsp_t want);
    if (rsp_i.status !== want.status) begin
      $error("status: expected %s, actual %0d", want.status.name(), rsp_i.status);
      mismatches++;
    end
    if (rsp_i.out_payload !== want.payload) begin
      $error("out_payload: expected %h, actual %h", want.payload, rsp_i.out_payload);
      mismatches++;
    end
    if (rsp_i.out_prio !== want.prio) begin
      $error("out_prio: expected %0d, actual %0d", want.prio, rsp_i.out_prio);
      mismatches++;
    end
    if (rsp_i.occupancy !== want.occ) begin
      $error("occupancy: expected %0d, actual %0d", want.occ, rsp_i.occupancy);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shadow_cnt = 0;
      expected_rsp_q.delete();
      mismatches = 0;
      stat_enq   = 0;
      stat_pop   = 0;
      stat_empty = 0;
      stat_full  = 0;
      stat_peak  = 0;
    end else begin
      if (req_i.valid === 1'b1 && req_i.ready === 1'b1) begin
        expected_rsp_q.push_back(apply_queue_cmd(cmd_e'(req_i.cmd), req_i.payload,
                                                 req_i.prio));
      end
      if (rsp_i.valid === 1'b1 && rsp_i.ready === 1'b1) begin
        if (expected_rsp_q.size() == 0) begin
          $error("response item with no request outstanding: status %0d", rsp_i.status);
          mismatches++;
        end else begin
          oldest_rsp = expected_rsp_q.pop_front();
          compare_rsp(oldest_rsp);
        end
      end
    end
    err_cnt_o   <= mismatches;
    pending_o   <= expected_rsp_q.size();
    enq_cnt_o   <= stat_enq;
    pop_cnt_o   <= stat_pop;
    empty_cnt_o <= stat_empty;
    full_cnt_o  <= stat_full;
    peak_occ_o  <= stat_peak;
  end

endmodule

// File: tb/sv/tb_sorted_priority_queue_unit.sv
// ----------------------------------------------------------------------------
// Sorted priority queue unit testbench
// Drives enqueue and dequeue items into the queue with random idling on both
// channels, including a long response stall, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_sorted_priority_queue_unit
  import spq_pkg::*;
();

  localparam int unsigned DEPTH         = DefaultDepth;
  localparam int          HoldCycles    = 300;
  localparam int          WatchdogLimit = 3000;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  spq_req_if req ();
  spq_rsp_if rsp ();

  int  send_idle_pct = 11;
  int  rsp_idle_pct  = 52;
  bit  hold_arm      = 1'b0;
  bit  hold_done     = 1'b0;
  int  stall_cycles  = 0;

  int  err_cnt, pending, enq_cnt, pop_cnt, empty_cnt, full_cnt, peak_occ;

  always #5 clk_i = ~clk_i;

  sorted_priority_queue_unit #(
    .DEPTH(DEPTH)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req),
    .rsp_o (rsp)
  );

  spq_queue_checker #(
    .DEPTH(DEPTH)
  ) u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req),
    .rsp_i      (rsp),
    .err_cnt_o  (err_cnt),
    .pending_o  (pending),
    .enq_cnt_o  (enq_cnt),
    .pop_cnt_o  (pop_cnt),
    .empty_cnt_o(empty_cnt),
    .full_cnt_o (full_cnt),
    .peak_occ_o (peak_occ)
  );

  function automatic logic [PayloadW-1:0] rand_payload();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  function automatic logic signed [PrioW-1:0] rand_prio();
    int v;
    case ($urandom_range(3))
      0: v = $urandom_range(6) - 3;
      1: begin
        case ($urandom_range(3))
          0: v = -32768;
          1: v = -32767;
          2: v = 32766;
          default: v = 32767;
        endcase
      end
      default: v = $urandom_range(65535);
    endcase
    return 16'(v);
  endfunction

  task automatic offer_cmd(input cmd_e cmd, input logic [PayloadW-1:0] pay,
                           input logic signed [PrioW-1:0] pr);
    while ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk_i);
    end
    req.valid   <= 1'b1;
    req.cmd     <= cmd;
    req.payload <= pay;
    req.prio    <= pr;
    do @(posedge clk_i); while (req.ready !== 1'b1);
  endtask

  task automatic random_cmds(input int count);
    int left;
    int seg_len;
    int enq_pct;
    left = count;
    while (left > 0) begin
      // Runs biased toward enqueue fill the queue, runs biased toward dequeue drain it.
      case ($urandom_range(2))
        0: enq_pct = 85;
        1: enq_pct = 50;
        default: enq_pct = 15;
      endcase
      seg_len = $urandom_range(40, 8);
      for (int i = 0; i < seg_len && left > 0; i++) begin
        if ($urandom_range(99) < enq_pct) offer_cmd(CMD_ENQ, rand_payload(), rand_prio());
        else offer_cmd(CMD_DEQ, rand_payload(), rand_prio());
        left--;
      end
    end
  endtask

  initial begin
    rsp.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_arm && !hold_done) begin
        hold_done = 1'b1;
        rsp.ready <= 1'b0;
        stall_cycles = 1;
        while (stall_cycles < HoldCycles) begin
          @(posedge clk_i);
          stall_cycles++;
        end
      end else begin
        rsp.ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
    end
  end

  int quiet_cycles = 0;

  always @(posedge clk_i) begin
    if ((req.valid === 1'b1 && req.ready === 1'b1) ||
        (rsp.valid === 1'b1 && rsp.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("tb_sorted_priority_queue_unit: done, errors");
      $finish;
    end
  end

  initial begin
    req.valid   <= 1'b0;
    req.cmd     <= CMD_ENQ;
    req.payload <= '0;
    req.prio    <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Dequeue from the empty queue, with its ignored fields set.
    offer_cmd(CMD_DEQ, '1, 16'sh7fff);
    offer_cmd(CMD_ENQ, '1, 16'sh7fff);
    offer_cmd(CMD_ENQ, '0, -16'sh8000);
    offer_cmd(CMD_ENQ, 64'ha5a5_a5a5_a5a5_a5a5, 16'sh0000);
    // Equal priority: the newer entry must come out first.
    offer_cmd(CMD_ENQ, 64'h5a5a_5a5a_5a5a_5a5a, 16'sh0000);
    offer_cmd(CMD_ENQ, 64'h0000_0000_0000_0001, -16'sh0001);
    offer_cmd(CMD_DEQ, '0, '0);
    offer_cmd(CMD_DEQ, 64'hdead_beef_0123_4567, -16'sh8000);
    for (int i = 0; i < 13; i++) begin
      offer_cmd(CMD_ENQ, rand_payload(), (i % 2 == 0) ? -16'sh8000 : 16'sh7fff);
    end
    // The queue is full now, so this enqueue is rejected.
    offer_cmd(CMD_ENQ, '1, -16'sh8000);
    offer_cmd(CMD_DEQ, '0, '0);

    random_cmds(620);

    send_idle_pct = 52;
    rsp_idle_pct  = 11;
    random_cmds(620);

    send_idle_pct = 0;
    rsp_idle_pct  = 0;
    hold_arm      = 1'b1;
    for (int i = 0; i < 40; i++) begin
      offer_cmd(($urandom_range(3) == 0) ? CMD_DEQ : CMD_ENQ, rand_payload(), rand_prio());
    end
    random_cmds(600);
    req.valid <= 1'b0;
    @(posedge clk_i);

    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    $display("Queue saw %0d enqueues, %0d pops, %0d empty dequeues, %0d rejected enqueues;",
             enq_cnt, pop_cnt, empty_cnt, full_cnt);
    $display("peak occupancy %0d of %0d entries, one %0d-cycle response stall.",
             peak_occ, DEPTH, HoldCycles);
    if (err_cnt == 0 && pending == 0) begin
      $display("tb_sorted_priority_queue_unit: done, clean");
    end else begin
      $display("tb_sorted_priority_queue_unit: done, errors");
    end
    $finish;
  end

endmodule
